[hdl/rau_pkg.sv]
// Package for the rational arithmetic unit: widths, mode and order codes,
// request and result types, magnitude and saturation helpers.
// No dependencies.
package rau_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;
  localparam int SUM_WIDTH     = PROD_WIDTH + 1;
  localparam int RES_WIDTH     = 32;
  localparam int EXT_WIDTH     = 66;
  localparam int CNT_WIDTH     = $clog2(OPERAND_WIDTH + 1);
  localparam int SHIFT_WIDTH   = $clog2(OPERAND_WIDTH);

  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_SUB = 3'd1;
  localparam logic [2:0] MODE_MUL = 3'd2;
  localparam logic [2:0] MODE_DIV = 3'd3;
  localparam logic [2:0] MODE_CMP = 3'd4;
  localparam logic [2:0] MODE_RED = 3'd5;

  localparam logic [1:0] ORDER_LESS    = 2'd0;
  localparam logic [1:0] ORDER_EQUAL   = 2'd1;
  localparam logic [1:0] ORDER_GREATER = 2'd2;

  typedef struct packed {
    logic [2:0]                      mode;
    logic signed [OPERAND_WIDTH-1:0] lhs_num;
    logic signed [OPERAND_WIDTH-1:0] lhs_den;
    logic signed [OPERAND_WIDTH-1:0] rhs_num;
    logic signed [OPERAND_WIDTH-1:0] rhs_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [RES_WIDTH-1:0] res_num;
    logic signed [RES_WIDTH-1:0] res_den;
    logic [1:0]                  order;
    logic                        overflow;
    logic                        zero_den;
  } rau_out_t;

  typedef struct packed {
    logic signed [RES_WIDTH-1:0] val;
    logic                        ovf;
  } sat_t;

  function automatic logic [OPERAND_WIDTH-1:0] mag(input logic signed [OPERAND_WIDTH-1:0] v);
    return v[OPERAND_WIDTH-1] ? OPERAND_WIDTH'(-v) : OPERAND_WIDTH'(v);
  endfunction

  function automatic sat_t sat_res(input logic signed [SUM_WIDTH-1:0] v);
    logic signed [EXT_WIDTH-1:0] e;
    sat_t r;
    e = EXT_WIDTH'(v);
    if (e > 66'sd2147483647) begin
      r.val = 32'sh7fffffff;
      r.ovf = 1'b1;
    end else if (e < -66'sd2147483648) begin
      r.val = 32'sh80000000;
      r.ovf = 1'b1;
    end else begin
      r.val = e[RES_WIDTH-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

endpackage

[hdl/rau_mul.sv]
// Bit-serial signed multiplier: shift-add on magnitudes, one bit per cycle,
// sign fixed in a final step. Depends on rau_pkg.
module rau_mul import rau_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic signed [OPERAND_WIDTH-1:0] x,
  input  logic signed [OPERAND_WIDTH-1:0] y,
  output logic                           done,
  output logic signed [PROD_WIDTH-1:0]   prod
);

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIX} mstate_t;

  mstate_t                  state;
  logic [OPERAND_WIDTH-1:0] mx;
  logic [OPERAND_WIDTH-1:0] hi;
  logic [OPERAND_WIDTH-1:0] lo;
  logic                     neg;
  logic [CNT_WIDTH-1:0]     cnt;
  logic [OPERAND_WIDTH:0]   sum;

  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, mx} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == M_FIX);
      case (state)
        M_IDLE: begin
          if (start) begin
            mx    <= mag(x);
            lo    <= mag(y);
            hi    <= '0;
            neg   <= x[OPERAND_WIDTH-1] ^ y[OPERAND_WIDTH-1];
            cnt   <= '0;
            state <= M_RUN;
          end
        end
        M_RUN: begin
          {hi, lo} <= {sum, lo[OPERAND_WIDTH-1:1]};
          cnt      <= cnt + 1'b1;
          if (cnt == CNT_WIDTH'(OPERAND_WIDTH - 1)) state <= M_FIX;
        end
        M_FIX: begin
          prod  <= neg ? -$signed({hi, lo}) : $signed({hi, lo});
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

[hdl/rau_gcd.sv]
// Binary gcd of two unsigned magnitudes, one halving or subtract step per
// cycle. First operand must be nonzero. Depends on rau_pkg.
module rau_gcd import rau_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [OPERAND_WIDTH-1:0] x_in,
  input  logic [OPERAND_WIDTH-1:0] y_in,
  output logic                     done,
  output logic [OPERAND_WIDTH-1:0] g
);

  typedef enum logic {G_IDLE, G_RUN} gstate_t;

  gstate_t                  state;
  logic [OPERAND_WIDTH-1:0] x;
  logic [OPERAND_WIDTH-1:0] y;
  logic [SHIFT_WIDTH-1:0]   k;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == G_RUN) && (x == '0 || y == '0);
      case (state)
        G_IDLE: begin
          if (start) begin
            x     <= x_in;
            y     <= y_in;
            k     <= '0;
            state <= G_RUN;
          end
        end
        G_RUN: begin
          if (x == '0) begin
            g     <= y << k;
            state <= G_IDLE;
          end else if (y == '0) begin
            g     <= x << k;
            state <= G_IDLE;
          end else if (!x[0] && !y[0]) begin
            x <= x >> 1;
            y <= y >> 1;
            k <= k + 1'b1;
          end else if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (x >= y) begin
            x <= (x - y) >> 1;
          end else begin
            y <= (y - x) >> 1;
          end
        end
        default: state <= G_IDLE;
      endcase
    end
  end

endmodule

[hdl/rau_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Divisor must be nonzero. Depends on rau_pkg.
module rau_div import rau_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [OPERAND_WIDTH-1:0] n,
  input  logic [OPERAND_WIDTH-1:0] d,
  output logic                     done,
  output logic [OPERAND_WIDTH-1:0] q
);

  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  dstate_t                  state;
  logic [OPERAND_WIDTH-1:0] rem;
  logic [OPERAND_WIDTH-1:0] quo;
  logic [OPERAND_WIDTH-1:0] dv;
  logic [CNT_WIDTH-1:0]     cnt;
  logic [OPERAND_WIDTH:0]   t;
  logic [OPERAND_WIDTH:0]   diff;
  logic                     ge;

  assign t    = {rem, quo[OPERAND_WIDTH-1]};
  assign ge   = t >= {1'b0, dv};
  assign diff = t - {1'b0, dv};
  assign q    = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == D_RUN) && (cnt == CNT_WIDTH'(OPERAND_WIDTH - 1));
      case (state)
        D_IDLE: begin
          if (start) begin
            rem   <= '0;
            quo   <= n;
            dv    <= d;
            cnt   <= '0;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          rem <= ge ? diff[OPERAND_WIDTH-1:0] : t[OPERAND_WIDTH-1:0];
          quo <= {quo[OPERAND_WIDTH-2:0], ge};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_WIDTH'(OPERAND_WIDTH - 1)) begin
            state <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

[hdl/rational_arithmetic_unit.sv]
// Rational arithmetic unit top level: sequencer over a bit-serial multiplier,
// binary gcd and serial divider. Depends on rau_pkg, rau_mul, rau_gcd, rau_div.
// Add, subtract and compare take three serial products; multiply and divide
// take two; reduce runs the gcd and then two serial divisions.
// One request in flight; the serial multiplier and gcd/divider set the time.
// Unused modes and zero-numerator reduce go from idle straight to the output state.
// Synchronous active-high reset clears sequencer and output valid.
module rational_arithmetic_unit import rau_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  rau_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output rau_out_t out_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_MWAIT, S_CALC, S_GCD, S_GWAIT,
    S_DIVA, S_DWA, S_DIVB, S_DWB, S_RED, S_DONE
  } state_t;

  state_t                          state;
  rau_in_t                         req;
  logic [1:0]                      slot;
  logic signed [PROD_WIDTH-1:0]    p0;
  logic signed [PROD_WIDTH-1:0]    p1;
  logic signed [PROD_WIDTH-1:0]    p2;
  logic [OPERAND_WIDTH-1:0]        gval;
  logic [OPERAND_WIDTH-1:0]        qa;
  rau_out_t                        res;

  logic signed [OPERAND_WIDTH-1:0] mul_x;
  logic signed [OPERAND_WIDTH-1:0] mul_y;
  logic                            mul_done;
  logic signed [PROD_WIDTH-1:0]    mul_prod;
  logic                            gcd_done;
  logic [OPERAND_WIDTH-1:0]        gcd_g;
  logic                            div_done;
  logic [OPERAND_WIDTH-1:0]        div_q;
  logic [OPERAND_WIDTH-1:0]        ua;
  logic [OPERAND_WIDTH-1:0]        ub;
  logic [1:0]                      last_slot;
  rau_out_t                        calc_res;
  rau_out_t                        red_res;

  logic signed [SUM_WIDTH-1:0]     e0;
  logic signed [SUM_WIDTH-1:0]     e1;
  logic signed [SUM_WIDTH-1:0]     e2;
  logic signed [SUM_WIDTH-1:0]     nsum;
  logic signed [SUM_WIDTH-1:0]     qsum;
  logic signed [OPERAND_WIDTH:0]   rn;
  logic signed [OPERAND_WIDTH:0]   rd;
  sat_t                            sn;
  sat_t                            sq;
  sat_t                            srn;
  sat_t                            srd;

  assign in_ready = (state == S_IDLE);
  assign ua = mag(req.lhs_num);
  assign ub = mag(req.lhs_den);
  assign last_slot = (req.mode == MODE_MUL || req.mode == MODE_DIV) ? 2'd1 : 2'd2;

  always_comb begin
    case (slot)
      2'd0: begin
        mul_x = req.lhs_num;
        mul_y = (req.mode == MODE_MUL) ? req.rhs_num : req.rhs_den;
      end
      2'd1: begin
        if (req.mode == MODE_MUL) begin
          mul_x = req.lhs_den;
          mul_y = req.rhs_den;
        end else if (req.mode == MODE_DIV) begin
          mul_x = req.lhs_den;
          mul_y = req.rhs_num;
        end else begin
          mul_x = req.rhs_num;
          mul_y = req.lhs_den;
        end
      end
      default: begin
        mul_x = req.lhs_den;
        mul_y = req.rhs_den;
      end
    endcase
  end

  always_comb begin
    e0   = SUM_WIDTH'(p0);
    e1   = SUM_WIDTH'(p1);
    e2   = SUM_WIDTH'(p2);
    nsum = (req.mode == MODE_ADD) ? e0 + e1 :
           (req.mode == MODE_SUB) ? e0 - e1 : e0;
    qsum = (req.mode == MODE_ADD || req.mode == MODE_SUB) ? e2 : e1;
    sn   = sat_res(nsum);
    sq   = sat_res(qsum);
    calc_res = '0;
    if (req.mode == MODE_CMP) begin
      calc_res.order    = (p0 < p1) ? ORDER_LESS : (p0 == p1) ? ORDER_EQUAL : ORDER_GREATER;
      calc_res.zero_den = (p2 == '0);
    end else begin
      calc_res.res_num  = sn.val;
      calc_res.res_den  = sq.val;
      calc_res.overflow = sn.ovf | sq.ovf;
      calc_res.zero_den = (qsum == '0);
    end
  end

  always_comb begin
    rn  = req.lhs_num[OPERAND_WIDTH-1] ? -$signed({1'b0, qa}) : $signed({1'b0, qa});
    rd  = req.lhs_den[OPERAND_WIDTH-1] ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
    srn = sat_res(SUM_WIDTH'(rn));
    srd = sat_res(SUM_WIDTH'(rd));
    red_res          = '0;
    red_res.res_num  = srn.val;
    red_res.res_den  = srd.val;
    red_res.overflow = srn.ovf | srd.ovf;
    red_res.zero_den = (rd == '0);
  end

  rau_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_MUL),
    .x     (mul_x),
    .y     (mul_y),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  rau_gcd u_gcd (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_GCD),
    .x_in  (ua),
    .y_in  (ub),
    .done  (gcd_done),
    .g     (gcd_g)
  );

  rau_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_DIVA || state == S_DIVB),
    .n     ((state == S_DIVB) ? ub : ua),
    .d     (gval),
    .done  (div_done),
    .q     (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req  <= in_data;
            slot <= 2'd0;
            if (in_data.mode == MODE_ADD || in_data.mode == MODE_SUB ||
                in_data.mode == MODE_MUL || in_data.mode == MODE_DIV ||
                in_data.mode == MODE_CMP) begin
              state <= S_MUL;
            end else if (in_data.mode == MODE_RED) begin
              if (in_data.lhs_num == '0) begin
                res   <= '{res_num: '0, res_den: 32'sd1, default: '0};
                state <= S_DONE;
              end else begin
                state <= S_GCD;
              end
            end else begin
              res   <= '0;
              state <= S_DONE;
            end
          end
        end
        S_MUL: state <= S_MWAIT;
        S_MWAIT: begin
          if (mul_done) begin
            case (slot)
              2'd0:    p0 <= mul_prod;
              2'd1:    p1 <= mul_prod;
              default: p2 <= mul_prod;
            endcase
            if (slot == last_slot) begin
              state <= S_CALC;
            end else begin
              slot  <= slot + 1'b1;
              state <= S_MUL;
            end
          end
        end
        S_CALC: begin
          res   <= calc_res;
          state <= S_DONE;
        end
        S_GCD: state <= S_GWAIT;
        S_GWAIT: begin
          if (gcd_done) begin
            gval  <= gcd_g;
            state <= S_DIVA;
          end
        end
        S_DIVA: state <= S_DWA;
        S_DWA: begin
          if (div_done) begin
            qa    <= div_q;
            state <= S_DIVB;
          end
        end
        S_DIVB: state <= S_DWB;
        S_DWB: begin
          if (div_done) state <= S_RED;
        end
        S_RED: begin
          res   <= red_res;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[verif/rau_checker.sv]
// Checker for the rational arithmetic unit: watches the request and result
// channels, predicts each result and compares it field by field.
// Depends on rau_pkg.
module rau_checker import rau_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_ready,
  input  rau_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  rau_out_t out_data,
  output int       errors,
  output int       pending,
  output int       results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  rau_out_t result_queue[$];

  function automatic logic signed [RES_WIDTH-1:0] clamp32(input longint v, inout logic ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic longint euclid(input longint x, input longint y);
    longint t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic rau_out_t rational_result(input rau_in_t req);
    longint a, b, c, d, n, q, g;
    logic ovf;
    logic arith;
    rau_out_t r;
    a = req.lhs_num;
    b = req.lhs_den;
    c = req.rhs_num;
    d = req.rhs_den;
    n = 0;
    q = 0;
    ovf = 1'b0;
    arith = 1'b1;
    r = '0;
    case (req.mode)
      MODE_ADD: begin
        n = a * d + c * b;
        q = b * d;
      end
      MODE_SUB: begin
        n = a * d - c * b;
        q = b * d;
      end
      MODE_MUL: begin
        n = a * c;
        q = b * d;
      end
      MODE_DIV: begin
        n = a * d;
        q = b * c;
      end
      MODE_CMP: begin
        arith = 1'b0;
        r.order = (a * d < c * b) ? ORDER_LESS :
                  (a * d == c * b) ? ORDER_EQUAL : ORDER_GREATER;
        r.zero_den = (b * d) == 0;
      end
      MODE_RED: begin
        if (a == 0) begin
          n = 0;
          q = 1;
        end else begin
          g = euclid(a < 0 ? -a : a, b < 0 ? -b : b);
          n = a / g;
          q = b / g;
        end
      end
      default: arith = 1'b0;
    endcase
    if (arith) begin
      r.res_num = clamp32(n, ovf);
      r.res_den = clamp32(q, ovf);
      r.overflow = ovf;
      r.zero_den = q == 0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch on result %0d: %s got %0d expected %0d", results_seen, what, got, want);
  endtask

  assign pending = result_queue.size();

  always @(posedge clk) begin
    rau_out_t want;
    if (rst) begin
      errors = 0;
      results_seen <= 0;
    end else begin
      if (in_valid && in_ready)
        result_queue.push_back(rational_result(in_data));
      if (out_valid && out_ready) begin
        if (result_queue.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          want = result_queue.pop_front();
          if (out_data.res_num !== want.res_num)
            report_mismatch("res_num", out_data.res_num, want.res_num);
          if (out_data.res_den !== want.res_den)
            report_mismatch("res_den", out_data.res_den, want.res_den);
          if (out_data.order !== want.order)
            report_mismatch("order", out_data.order, want.order);
          if (out_data.overflow !== want.overflow)
            report_mismatch("overflow", out_data.overflow, want.overflow);
          if (out_data.zero_den !== want.zero_den)
            report_mismatch("zero_den", out_data.zero_den, want.zero_den);
        end
        results_seen <= results_seen + 1;
      end
    end
  end
endmodule

[verif/tb_rational_arithmetic_unit.sv]
// Testbench top for the rational arithmetic unit: clock, reset, directed and
// random requests, random idling, verdict. Needs rau_pkg, the unit, rau_checker.
module tb_rational_arithmetic_unit;
  import rau_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQUESTS = 1000;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam logic [2:0] MODE_UNUSED6 = 3'd6;
  localparam logic [2:0] MODE_UNUSED7 = 3'd7;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  rau_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  rau_out_t out_data;
  int       errors, pending, results_seen;
  int       cycles = 0;
  int       send_idle_pct = 11;
  int       recv_idle_pct = 60;
  int       sent = 0;

  always #5 clk = ~clk;

  rational_arithmetic_unit dut (.*);

  rau_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst)
      out_ready <= 1'b0;
    else
      out_ready <= $urandom_range(99) >= recv_idle_pct;
  end

  function automatic logic signed [15:0] pick_operand();
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'(int'($urandom_range(6)) - 3);
      3: return 16'(int'($urandom_range(200)) - 100);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_request(input rau_in_t req);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    sent++;
  endtask

  task automatic directed(input logic [2:0] m, input int a, input int b, input int c,
                          input int d);
    rau_in_t req;
    req.mode = m;
    req.lhs_num = 16'(a);
    req.lhs_den = 16'(b);
    req.rhs_num = 16'(c);
    req.rhs_den = 16'(d);
    send_request(req);
  endtask

  initial begin
    rau_in_t req;
    int phase;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed(MODE_ADD, 32767, 1, 32767, 1);
    directed(MODE_ADD, -32768, -32768, -32768, -32768);
    directed(MODE_ADD, -32768, 1, -32768, -32768);
    directed(MODE_ADD, 32767, -32768, 32767, -32768);
    directed(MODE_SUB, -32768, -32768, 32767, 32767);
    directed(MODE_SUB, 1, 2, 1, 3);
    directed(MODE_MUL, -32768, -32768, -32768, -32768);
    directed(MODE_MUL, 3, 0, 5, 7);
    directed(MODE_DIV, 1, 2, 0, 5);
    directed(MODE_DIV, -32768, 32767, 32767, -32768);
    directed(MODE_CMP, 1, 2, 2, 4);
    directed(MODE_CMP, 1, 3, 1, 2);
    directed(MODE_CMP, 2, 3, 1, 2);
    directed(MODE_CMP, 1, 0, 1, 2);
    directed(MODE_RED, 0, 0, 7, 7);
    directed(MODE_RED, 0, -5, 0, 0);
    directed(MODE_RED, -12, 0, 0, 0);
    directed(MODE_RED, 12, 0, 0, 0);
    directed(MODE_RED, -32768, -32768, 0, 0);
    directed(MODE_RED, 12, -18, 0, 0);
    directed(MODE_RED, -32768, 32767, 0, 0);
    directed(MODE_UNUSED6, 5, 6, 7, 8);
    directed(MODE_UNUSED7, -1, -1, -1, -1);
    directed(MODE_ADD, 0, 0, 0, 0);
    directed(MODE_ADD, -1, -1, -1, -1);
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 60 : 0;
      recv_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 11 : 0;
      repeat (RANDOM_REQUESTS / 3) begin
        req.mode = ($urandom_range(15) == 0) ? 3'($urandom_range(7, 6))
                                             : 3'($urandom_range(5));
        req.lhs_num = pick_operand();
        req.lhs_den = pick_operand();
        req.rhs_num = pick_operand();
        req.rhs_den = pick_operand();
        send_request(req);
      end
    end
    in_valid <= 1'b0;
    while (pending != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d requests over all six modes and both unused codes,", sent);
    $display("checked %0d results under three idling patterns", results_seen);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end
endmodule

[filelist.f]
hdl/rau_pkg.sv
hdl/rau_mul.sv
hdl/rau_gcd.sv
hdl/rau_div.sv
hdl/rational_arithmetic_unit.sv
verif/rau_checker.sv
verif/tb_rational_arithmetic_unit.sv
